// ===== hdl/tpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and fixed widths for the page table translator.
// ----------------------------------------------------------------------------
package tpt_pkg;

    localparam int VA_W    = 19;          // virtual address word
    localparam int PA_W    = 18;          // physical address word
    localparam int FRAME_W = 6;           // stored frame number
    localparam int TAG_W   = 7;           // page tag held in the TLB
    localparam int MAP_W   = FRAME_W + 1; // page map word: {valid, frame}

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_LOOK
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_rsp;

    typedef struct packed {
        logic               go;    // commit a translation
        logic               fill;  // miss: load the victim entry
        logic [TAG_W-1:0]   tag;
        logic [FRAME_W-1:0] frame;
    } t_tlb_upd;

endpackage

// ===== hdl/tpt_page_mem.sv =====
// ----------------------------------------------------------------------------
// tpt_page_mem
// Page map memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tpt_page_mem #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic [tpt_pkg::MAP_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0]       i_raddr,
    output logic [tpt_pkg::MAP_W-1:0] o_rdata
);
    import tpt_pkg::*;

    logic [MAP_W-1:0] mem [DEPTH];
    logic [MAP_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tpt_tlb.sv =====
// ----------------------------------------------------------------------------
// tpt_tlb
// Fully associative TLB with saturating per-entry ages; oldest entry is the
// victim on a miss, lowest index on ties.
// ----------------------------------------------------------------------------
module tpt_tlb #(
    parameter int ENTRIES = 4,
    parameter int AGE_MAX = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [tpt_pkg::TAG_W-1:0] i_tag,
    output tpt_pkg::t_tlb_rsp         o_rsp,
    input  tpt_pkg::t_tlb_upd         i_upd
);
    import tpt_pkg::*;

    localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W  = $clog2(AGE_MAX + 1);

    logic [ENTRIES-1:0] r_valid;
    logic [TAG_W-1:0]   r_tag   [ENTRIES];
    logic [FRAME_W-1:0] r_frame [ENTRIES];
    logic [AGE_W-1:0]   r_age   [ENTRIES];

    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic [FRAME_W-1:0] hit_frame;
    logic [SLOT_W-1:0]  victim;
    logic [AGE_W-1:0]   best;
    logic [SLOT_W-1:0]  used;

    // lowest matching index wins: scan down so lower indices override
    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        hit_frame = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == i_tag) begin
                hit       = 1'b1;
                hit_slot  = SLOT_W'(i);
                hit_frame = r_frame[i];
            end
        end
    end

    // greatest age, strict compare keeps the lowest index on ties
    always_comb begin
        best   = r_age[0];
        victim = '0;
        for (int i = 1; i < ENTRIES; i++) begin
            if (r_age[i] > best) begin
                best   = r_age[i];
                victim = SLOT_W'(i);
            end
        end
    end

    assign used        = hit ? hit_slot : victim;
    assign o_rsp.hit   = hit;
    assign o_rsp.frame = hit_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_age[i] <= AGE_W'(AGE_MAX);
            end
        end else if (i_upd.go) begin
            if (i_upd.fill) begin
                r_valid[victim] <= 1'b1;
            end
            for (int i = 0; i < ENTRIES; i++) begin
                if (SLOT_W'(i) == used) begin
                    r_age[i] <= '0;
                end else if (r_age[i] < AGE_W'(AGE_MAX)) begin
                    r_age[i] <= r_age[i] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd.go && i_upd.fill) begin
            r_tag[victim]   <= i_upd.tag;
            r_frame[victim] <= i_upd.frame;
        end
    end

endmodule

// ===== hdl/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical address translation through a small TLB and a page map
// with lowest-free frame allocation on page faults.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps all NUM_PAGES entries (128 by default)
// of the page map to clear them, with busy high. Then a word is taken on any
// cycle with start high and busy low. With NUM_PAGES a power of two the
// accept cycle launches the page map read, the next cycle sees the read data
// and the TLB compare and commits all updates, and o_valid pulses in the
// cycle after that, when the next word may already be taken. Otherwise the
// page number is reduced modulo NUM_PAGES one conditional subtract per cycle
// and the map read gets its own state before the lookup. The result appears
// on the o_ ports with o_valid, which is high for exactly one cycle; the
// receiver cannot stall the block, so it must take every strobe.
// On out of memory (page fault with every frame taken) nothing changes and the
// result reads address 0, frame 0, page_fault 1, status 1.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
    parameter int OFFSET_BITS = 12,
    parameter int TLB_ENTRIES = 4,
    parameter int NUM_FRAMES  = 64,
    parameter int NUM_PAGES   = 128,
    parameter int AGE_MAX     = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tpt_pkg::VA_W-1:0]    i_virtual_address,
    output logic                        o_valid,
    output logic [tpt_pkg::PA_W-1:0]    o_physical_address,
    output logic [tpt_pkg::FRAME_W-1:0] o_frame_number,
    output logic                        o_tlb_hit,
    output logic                        o_page_fault,
    output logic                        o_status
);
    import tpt_pkg::*;

    localparam int RAW_W  = VA_W - OFFSET_BITS;          // raw page number
    localparam int PAGE_W = $clog2(NUM_PAGES);           // map index
    localparam int EXT_W  = (RAW_W > PAGE_W) ? RAW_W : PAGE_W;
    localparam int SUB_W  = RAW_W + PAGE_W + 1;          // modulo datapath
    localparam int STEP_W = $clog2(RAW_W);
    localparam int CNT_W  = $clog2(NUM_FRAMES + 1);      // frames allocated
    localparam int FP_W   = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
    localparam bit POW2   = ((NUM_PAGES & (NUM_PAGES - 1)) == 0);

    // control state
    t_state            r_state, n_state;
    logic [PAGE_W-1:0] r_clr, n_clr;
    logic [CNT_W-1:0]  r_used, n_used;   // frames 0..r_used-1 are taken
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_valid, n_valid;

    // word in flight
    logic [PAGE_W-1:0]      r_page, n_page;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [RAW_W-1:0]       r_rem, n_rem;

    // result registers
    logic [PA_W-1:0]    r_pa, n_pa;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               r_hit, n_hit;
    logic               r_fault, n_fault;
    logic               r_status, n_status;

    // page map port
    logic              mem_we;
    logic [PAGE_W-1:0] mem_waddr;
    logic [MAP_W-1:0]  mem_wdata;
    logic [PAGE_W-1:0] mem_raddr;
    logic [MAP_W-1:0]  mem_rdata;

    t_tlb_rsp tlb_rsp;
    t_tlb_upd tlb_upd;

    // address split
    logic [RAW_W-1:0]  va_raw;
    logic [EXT_W-1:0]  va_ext;
    logic [PAGE_W-1:0] va_page;
    logic [EXT_W-1:0]  rem_ext;
    logic [PAGE_W-1:0] rem_page;
    logic [SUB_W-1:0]  mod_sub;
    logic              mod_ok;

    // lookup
    logic               map_valid;
    logic [FRAME_W-1:0] map_frame;
    logic               fault;
    logic               oom;
    logic [FRAME_W-1:0] frame6;
    logic [FP_W-1:0]    frame_pa;

    assign va_raw   = i_virtual_address[VA_W-1:OFFSET_BITS];
    assign va_ext   = EXT_W'(va_raw);
    assign va_page  = va_ext[PAGE_W-1:0];
    assign rem_ext  = EXT_W'(r_rem);
    assign rem_page = rem_ext[PAGE_W-1:0];
    assign mod_sub  = SUB_W'(NUM_PAGES) << r_step;
    assign mod_ok   = SUB_W'(r_rem) >= mod_sub;

    assign map_valid = mem_rdata[FRAME_W];
    assign map_frame = mem_rdata[FRAME_W-1:0];
    assign fault     = !tlb_rsp.hit && !map_valid;
    assign oom       = fault && (r_used == CNT_W'(NUM_FRAMES));

    // a new frame keeps its full count for the address; stores keep 6 bits
    always_comb begin
        if (tlb_rsp.hit) begin
            frame6   = tlb_rsp.frame;
            frame_pa = FP_W'(tlb_rsp.frame);
        end else if (map_valid) begin
            frame6   = map_frame;
            frame_pa = FP_W'(map_frame);
        end else begin
            frame6   = FRAME_W'(r_used);
            frame_pa = FP_W'(r_used);
        end
    end

    tpt_page_mem #(
        .DEPTH  (NUM_PAGES),
        .ADDR_W (PAGE_W)
    ) u_page_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tpt_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .AGE_MAX (AGE_MAX)
    ) u_tlb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (TAG_W'(r_page)),
        .o_rsp   (tlb_rsp),
        .i_upd   (tlb_upd)
    );

    // next state, memory port and result
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_used    = r_used;
        n_step    = r_step;
        n_page    = r_page;
        n_off     = r_off;
        n_rem     = r_rem;
        n_valid   = 1'b0;
        n_pa      = r_pa;
        n_frame   = r_frame;
        n_hit     = r_hit;
        n_fault   = r_fault;
        n_status  = r_status;
        mem_we    = 1'b0;
        mem_waddr = r_page;
        mem_wdata = '0;
        mem_raddr = r_page;
        tlb_upd   = '0;

        unique case (r_state)
            S_CLEAR: begin
                // write every map entry as unmapped
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + 1'b1;
                if (r_clr == PAGE_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                mem_raddr = va_page;
                if (start) begin
                    n_off   = i_virtual_address[OFFSET_BITS-1:0];
                    n_page  = va_page;
                    n_rem   = va_raw;
                    n_step  = STEP_W'(RAW_W - 1);
                    n_state = POW2 ? S_LOOK : S_MOD;
                end
            end
            S_MOD: begin
                // restoring reduction, one shifted modulus per cycle
                if (mod_ok) begin
                    n_rem = RAW_W'(SUB_W'(r_rem) - mod_sub);
                end
                if (r_step == '0) begin
                    n_state = S_READ;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_READ: begin
                mem_raddr = rem_page;
                n_page    = rem_page;
                n_state   = S_LOOK;
            end
            S_LOOK: begin
                n_valid  = 1'b1;
                n_hit    = tlb_rsp.hit;
                n_fault  = fault;
                n_status = oom;
                if (oom) begin
                    n_pa    = '0;
                    n_frame = '0;
                end else begin
                    n_pa          = PA_W'({frame_pa, r_off});
                    n_frame       = frame6;
                    tlb_upd.go    = 1'b1;
                    tlb_upd.fill  = !tlb_rsp.hit;
                    tlb_upd.tag   = TAG_W'(r_page);
                    tlb_upd.frame = frame6;
                    if (fault) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_page;
                        mem_wdata = {1'b1, frame6};
                        n_used    = r_used + 1'b1;
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_used  <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_used  <= n_used;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_page   <= n_page;
        r_off    <= n_off;
        r_rem    <= n_rem;
        r_pa     <= n_pa;
        r_frame  <= n_frame;
        r_hit    <= n_hit;
        r_fault  <= n_fault;
        r_status <= n_status;
    end

    assign busy               = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid            = r_valid;
    assign o_physical_address = r_pa;
    assign o_frame_number     = r_frame;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_status           = r_status;

`ifndef SYNTHESIS
    // out of memory reports a bare fault with a zero address
    a_oom_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_page_fault && !o_tlb_hit &&
                                   o_physical_address == '0 && o_frame_number == '0))
        else $error("out of memory word carries a translation");

    // frame allocation never runs past the frame count
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(NUM_FRAMES))
        else $error("frame allocation count overflow");

    // power of two page count: result strobe follows the look state that comes right after accept
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && POW2) |=> ##1 o_valid)
        else $error("result word missing after accept");
`endif

endmodule
